>>> hdl/msort_pkg.sv
`default_nettype none

package msort_pkg;

    localparam int unsigned DataWidth = 32;

    typedef struct packed {
        logic signed [DataWidth-1:0] value;
        logic                        last_in;
    } t_in_item;

    typedef struct packed {
        logic signed [DataWidth-1:0] sorted_value;
        logic                        last_out;
        logic                        overflowed;
    } t_out_item;

    // What one cell shows its neighbours.
    typedef struct packed {
        logic                        valid;
        logic                        gt;
        logic signed [DataWidth-1:0] value;
    } t_cell_out;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic                        insert;
        logic                        shift_out;
        logic signed [DataWidth-1:0] new_value;
    } t_cell_ctl;

    typedef enum logic {
        ST_LOAD,
        ST_DRAIN
    } t_state;

endpackage

`default_nettype wire

>>> hdl/msort_cell.sv
`default_nettype none

module msort_cell (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire msort_pkg::t_cell_ctl  i_ctl,
    input  wire msort_pkg::t_cell_out  i_left,
    input  wire msort_pkg::t_cell_out  i_right,
    output msort_pkg::t_cell_out       o_cell
);

    logic                                   r_valid;
    logic                                   n_valid;
    logic signed [msort_pkg::DataWidth-1:0] r_value;
    logic signed [msort_pkg::DataWidth-1:0] n_value;
    logic                                   gt;

    assign gt = r_valid && (i_ctl.new_value < r_value);

    always_comb begin
        n_valid = r_valid;
        n_value = r_value;
        if (i_ctl.insert) begin
            if (gt || (!r_valid && i_left.valid)) begin
                n_valid = 1'b1;
                n_value = i_left.gt ? i_left.value : i_ctl.new_value;
            end
        end else if (i_ctl.shift_out) begin
            n_valid = i_right.valid;
            n_value = i_right.value;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

    assign o_cell.valid = r_valid;
    assign o_cell.gt    = gt;
    assign o_cell.value = r_value;

endmodule

`default_nettype wire

>>> hdl/merge_insertion_sorter_core.sv
// Channel | Direction | Handshake                  | Beat
// --------+-----------+----------------------------+---------------------------------
// in      | input     | i_in_valid / o_in_stall    | value, last_in
// out     | output    | o_out_valid / i_out_stall  | sorted_value, last_out, overflowed
//
// Loading takes one value per cycle; every cell compares the broadcast value
// with its own entry and the row shifts right past the insertion point.
// After the beat marked last_in the row drains from cell 0, one beat per cycle
// that the output is not stalled. Input is stalled while draining. Synchronous
// active-low reset empties the row and clears the overflow flag.
`default_nettype none

module merge_insertion_sorter_core #(
    parameter int unsigned MAX_ITEMS = 32
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire msort_pkg::t_in_item  i_in_data,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output msort_pkg::t_out_item      o_out_data
);

    msort_pkg::t_state    r_state;
    msort_pkg::t_state    n_state;
    logic                 r_ovf;
    logic                 n_ovf;
    msort_pkg::t_cell_ctl ctl;
    msort_pkg::t_cell_out cell_q [MAX_ITEMS];
    msort_pkg::t_cell_out edge_left;
    msort_pkg::t_cell_out edge_right;
    logic                 in_acc;
    logic                 out_acc;
    logic                 full;
    logic                 final_beat;

    assign edge_left  = '{valid: 1'b1, gt: 1'b0, value: '0};
    assign edge_right = '{valid: 1'b0, gt: 1'b0, value: '0};

    assign full       = cell_q[MAX_ITEMS-1].valid;
    assign o_in_stall = (r_state == msort_pkg::ST_DRAIN);
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_out_valid = (r_state == msort_pkg::ST_DRAIN) && cell_q[0].valid;
    assign out_acc    = o_out_valid && !i_out_stall;
    assign final_beat = !cell_q[1].valid;

    assign ctl.insert    = in_acc && !full;
    assign ctl.shift_out = out_acc;
    assign ctl.new_value = i_in_data.value;

    assign o_out_data.sorted_value = cell_q[0].value;
    assign o_out_data.last_out     = final_beat;
    assign o_out_data.overflowed   = r_ovf;

    for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
        msort_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_left  ((g == 0) ? edge_left : cell_q[(g == 0) ? 0 : g-1]),
            .i_right ((g == MAX_ITEMS-1) ? edge_right
                                         : cell_q[(g == MAX_ITEMS-1) ? g : g+1]),
            .o_cell  (cell_q[g])
        );
    end

    always_comb begin
        n_state = r_state;
        n_ovf   = r_ovf;
        case (r_state)
            msort_pkg::ST_LOAD: begin
                if (in_acc) begin
                    if (full) begin
                        n_ovf = 1'b1;
                    end
                    if (i_in_data.last_in) begin
                        n_state = msort_pkg::ST_DRAIN;
                    end
                end
            end
            msort_pkg::ST_DRAIN: begin
                if (out_acc && final_beat) begin
                    n_state = msort_pkg::ST_LOAD;
                    n_ovf   = 1'b0;
                end
            end
            default: begin
                n_state = msort_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= msort_pkg::ST_LOAD;
            r_ovf   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ovf   <= n_ovf;
        end
    end

`ifndef NO_ASSERTIONS
    a_drain_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == msort_pkg::ST_DRAIN |-> cell_q[0].valid)
        else $error("drain with empty row");

    a_last_ends_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_acc && o_out_data.last_out |=> r_state == msort_pkg::ST_LOAD && !cell_q[0].valid)
        else $error("row not empty after last beat");

    a_ovf_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_ovf) |-> $past(full))
        else $error("overflow flagged with room left");

    a_no_insert_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        full |=> cell_q[MAX_ITEMS-1].valid || $past(out_acc))
        else $error("full row lost an entry");
`endif

endmodule

`default_nettype wire

>>> tb/sv/tb_merge_insertion_sorter_core.sv
module tb_merge_insertion_sorter_core;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned MAX_ITEMS   = 32;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned SETTLE      = MAX_ITEMS + 8;
    localparam int unsigned CYCLE_LIMIT = 250000;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    msort_pkg::t_in_item  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    msort_pkg::t_out_item out_data;

    logic calm      = 1'b0;
    logic hold_want = 1'b0;

    // sender side
    msort_pkg::t_in_item pending_beats[$];
    int unsigned         send_gap = 0;

    // receiver side
    int unsigned stall_left   = 0;
    int unsigned hold_left    = 0;
    logic        hold_started = 1'b0;

    // predicted contents of the row
    logic signed [msort_pkg::DataWidth-1:0] sorted_row[MAX_ITEMS];
    int unsigned                            row_count    = 0;
    logic                                   row_overflow = 1'b0;
    msort_pkg::t_out_item                   sorted_expect[$];

    int unsigned fail_count  = 0;
    int unsigned cycle_count = 0;

    merge_insertion_sorter_core #(
        .MAX_ITEMS (MAX_ITEMS)
    ) DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void absorb_beat(msort_pkg::t_in_item beat);
        int unsigned          pos;
        msort_pkg::t_out_item res;
        if (row_count < MAX_ITEMS) begin
            pos = row_count;
            while (pos > 0 && beat.value < sorted_row[pos-1]) begin
                sorted_row[pos] = sorted_row[pos-1];
                pos--;
            end
            sorted_row[pos] = beat.value;
            row_count++;
        end else begin
            row_overflow = 1'b1;
        end
        if (beat.last_in) begin
            for (int unsigned k = 0; k < row_count; k++) begin
                res.sorted_value = sorted_row[k];
                res.last_out     = (k + 1 == row_count);
                res.overflowed   = row_overflow;
                sorted_expect.insert(sorted_expect.size(), res);
            end
            row_count    = 0;
            row_overflow = 1'b0;
        end
    endfunction

    function automatic logic [msort_pkg::DataWidth-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return 32'h8000_0000;
            1:       return 32'h7fff_ffff;
            2, 3:    return 32'($urandom_range(0, 6)) - 32'd3;
            default: return $urandom();
        endcase
    endfunction

    task automatic queue_beat(input logic [msort_pkg::DataWidth-1:0] v, input logic last);
        msort_pkg::t_in_item beat;
        beat.value   = v;
        beat.last_in = last;
        pending_beats.insert(pending_beats.size(), beat);
    endtask

    task automatic queue_set(input int unsigned n);
        for (int unsigned k = 0; k < n; k++) begin
            queue_beat(pick_value(), k + 1 == n);
        end
    endtask

    // mostly short sets, some that fill the row, a few that overrun it
    task automatic queue_random_sets(input int unsigned budget);
        int unsigned used;
        int unsigned n;
        used = 0;
        while (used < budget) begin
            case ($urandom_range(0, 9))
                0:       n = $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 8);
                1, 2:    n = $urandom_range(9, MAX_ITEMS);
                default: n = $urandom_range(1, 8);
            endcase
            queue_set(n);
            used += n;
        end
    endtask

    // driver
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_gap <= 0;
        end else begin
            if (in_valid && !in_stall) begin
                absorb_beat(in_data);
            end
            if (!(in_valid && in_stall)) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    in_valid <= 1'b0;
                end else if (pending_beats.size() > 0) begin
                    in_data  <= pending_beats.pop_front();
                    in_valid <= 1'b1;
                    if (!calm && $urandom_range(0, 7) == 0) begin
                        send_gap <= $urandom_range(1, 18);
                    end
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall    <= 1'b0;
            stall_left   <= 0;
            hold_left    <= 0;
            hold_started <= 1'b0;
        end else if (hold_want && !hold_started) begin
            hold_started <= 1'b1;
            hold_left    <= LONG_HOLD;
            out_stall    <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            out_stall  <= 1'b1;
        end else if (!calm && $urandom_range(0, 6) == 0) begin
            stall_left <= $urandom_range(1, 18) - 1;
            out_stall  <= 1'b1;
        end else begin
            out_stall <= 1'b0;
        end
    end

    // monitor
    always @(posedge clk) begin
        msort_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (sorted_expect.size() == 0) begin
                fail_count++;
                if (fail_count <= 10) begin
                    $display("unexpected beat: value %0d last %0b overflow %0b",
                             out_data.sorted_value, out_data.last_out, out_data.overflowed);
                end
            end else begin
                want = sorted_expect.pop_front();
                if (out_data.sorted_value !== want.sorted_value
                        || out_data.last_out !== want.last_out
                        || out_data.overflowed !== want.overflowed) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("mismatch: want %0d last %0b ovf %0b, got %0d last %0b ovf %0b",
                                 want.sorted_value, want.last_out, want.overflowed,
                                 out_data.sorted_value, out_data.last_out,
                                 out_data.overflowed);
                    end
                end
            end
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        queue_beat(32'h8000_0000, 1'b1);
        queue_beat(32'h7fff_ffff, 1'b0);
        queue_beat(32'h8000_0000, 1'b0);
        queue_beat(32'h0000_0000, 1'b0);
        queue_beat(32'hffff_ffff, 1'b0);
        queue_beat(32'h0000_0001, 1'b0);
        queue_beat(32'h0000_0000, 1'b0);
        queue_beat(32'haaaa_aaaa, 1'b0);
        queue_beat(32'h5555_5555, 1'b0);
        queue_beat(32'h7fff_ffff, 1'b1);
        for (int k = 5; k >= 1; k--) begin
            queue_beat(32'(k), k == 1);
        end
        for (int k = 0; k < 3; k++) begin
            queue_beat(32'd7, k == 2);
        end
        queue_beat(32'h7fff_ffff, 1'b1);

        // exactly full, last beat dropped, and a long overrun
        queue_set(MAX_ITEMS);
        queue_set(MAX_ITEMS + 1);
        queue_set(MAX_ITEMS + 4);
        queue_random_sets(120);

        queue_random_sets(160);
        @(posedge clk);
        hold_want <= 1'b1;

        while (pending_beats.size() != 0 || in_valid || sorted_expect.size() != 0) begin
            @(posedge clk);
        end
        calm <= 1'b1;
        queue_random_sets(100);

        while (pending_beats.size() != 0 || in_valid || sorted_expect.size() != 0) begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
        if (fail_count == 0 && sorted_expect.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
